### rtl/core/xor_checked_response_deframer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the response deframer
// Shared property forms used by the concurrent checks at the end of the top.
// ---------------------------------------------------------------------------
`ifndef XOR_CHECKED_RESPONSE_DEFRAMER_DEFINES_SVH
`define XOR_CHECKED_RESPONSE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define XCRD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define XCRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/xcrd_pkg.sv
// ---------------------------------------------------------------------------
// xcrd_pkg
// Constants and widths for the XOR-checked response deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package xcrd_pkg;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 9;
   // result word: out_byte, byte_index, frame_good, response_id, payload_length
   localparam int RSP_FIELDS_W = 4 * BYTE_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] START_MARK = 8'h7E;

   // frame positions
   localparam logic [POS_W-1:0] POS_START = 9'd0;
   localparam logic [POS_W-1:0] POS_ID    = 9'd1;
   localparam logic [POS_W-1:0] POS_LEN   = 9'd2;
   localparam logic [POS_W-1:0] POS_EXTRA = 9'd3;
   localparam logic [POS_W-1:0] POS_BODY  = 9'd4;
   localparam logic [POS_W-1:0] POS_LAST  = 9'd259;

endpackage

`default_nettype wire

### rtl/core/xor_checked_response_deframer.sv
// ---------------------------------------------------------------------------
// xor_checked_response_deframer
// Parses a received byte stream into length-prefixed frames, XOR checked.
// ---------------------------------------------------------------------------
// Usage:
//  req channel carries one received byte per word in req_tdata; req_tuser
//  high forces that byte to be the start byte of a new frame, dropping any
//  frame in progress without a verdict.
//  Frame: start, id, length L, extra header byte, L payload bytes, checksum.
//  rsp channel gives one word per payload byte (rsp_tuser high, index in
//  byte_index) and one verdict word on the checksum byte (rsp_tlast high),
//  good only if the XOR of id..last payload byte matches and the start byte
//  was 0x7E; id and length read zero on a bad verdict. Header bytes give
//  no word.
//  An accepted word is held in the input register; its result is then
//  registered in the result register and shown on rsp from there.
//  Throughput: one word per cycle while rsp is not stalled, set by the
//  single pass from the input register through the position counter, XOR
//  and compare to the result register. A stalled rsp holds its word and
//  stops the input register; req_tready follows. Synchronous reset clears
//  the parser state and both valid flags; the next byte is a start byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xor_checked_response_deframer_defines.svh"

module xor_checked_response_deframer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input byte stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [xcrd_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
   input  wire logic                             req_tuser,   // [0] frame_begin
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] out_byte, [15:8] byte_index, [16] frame_good,
   // [24:17] response_id, [32:25] payload_length, rest zero
   output logic [xcrd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,   // frame_done
   output logic                                  rsp_tuser    // [0] payload_flag
);

   import xcrd_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic              in_begin_ff, in_begin_in;

   // parser state
   logic [POS_W-1:0]  pos_ff,   pos_in;
   logic [BYTE_W-1:0] xsum_ff,  xsum_in;
   logic [BYTE_W-1:0] len_ff,   len_in;
   logic [BYTE_W-1:0] id_ff,    id_in;
   logic              start_ok_ff, start_ok_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff,  out_data_in;
   logic                  out_last_ff,  out_last_in;
   logic                  out_user_ff,  out_user_in;

   // pass signals
   logic              advance;
   logic [POS_W-1:0]  pos_eff;
   logic [POS_W-1:0]  body_k;
   logic              is_payload;
   logic              is_verdict;
   logic              good;
   logic [RSP_DATA_W-1:0] res_data;

   // handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_begin_in = in_begin_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_begin_in = req_tuser;
      end
   end

   // frame position decode
   assign pos_eff    = in_begin_ff ? POS_START : pos_ff;
   assign body_k     = pos_eff - POS_BODY;
   assign is_payload = (pos_eff >= POS_BODY) && (body_k < {1'b0, len_ff});
   assign is_verdict = (pos_eff >= POS_BODY) && !is_payload;
   assign good       = start_ok_ff && (in_byte_ff == xsum_ff);

   // parser state update
   always_comb begin
      pos_in      = pos_ff;
      xsum_in     = xsum_ff;
      len_in      = len_ff;
      id_in       = id_ff;
      start_ok_in = start_ok_ff;
      if (advance) begin
         if (pos_eff == POS_START) begin
            start_ok_in = (in_byte_ff == START_MARK);
            xsum_in     = '0;
            id_in       = '0;
            len_in      = '0;
            pos_in      = POS_ID;
         end else if (pos_eff == POS_ID) begin
            id_in   = in_byte_ff;
            xsum_in = in_byte_ff;
            pos_in  = POS_LEN;
         end else if (pos_eff == POS_LEN) begin
            len_in  = in_byte_ff;
            xsum_in = xsum_ff ^ in_byte_ff;
            pos_in  = POS_EXTRA;
         end else if (pos_eff == POS_EXTRA) begin
            xsum_in = xsum_ff ^ in_byte_ff;
            pos_in  = POS_BODY;
         end else if (is_payload) begin
            xsum_in = xsum_ff ^ in_byte_ff;
            pos_in  = pos_eff + 9'd1;
         end else begin
            pos_in  = POS_START;
         end
      end
   end

   // result word packing
   always_comb begin
      res_data = '0;
      if (is_payload) begin
         res_data[7:0]  = in_byte_ff;
         res_data[15:8] = body_k[BYTE_W-1:0];
      end else begin
         res_data[16]    = good;
         res_data[24:17] = good ? id_ff  : '0;
         res_data[32:25] = good ? len_ff : '0;
      end
   end

   // result register load
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in = in_valid_ff && (is_payload || is_verdict);
         out_data_in  = res_data;
         out_last_in  = is_verdict;
         out_user_in  = is_payload;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_START;
         xsum_ff      <= '0;
         len_ff       <= '0;
         id_ff        <= '0;
         start_ok_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         xsum_ff      <= xsum_in;
         len_ff       <= len_in;
         id_ff        <= id_in;
         start_ok_ff  <= start_ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_begin_ff <= in_begin_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

   // checks
   `XCRD_ASSERT_IMPLY(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_LAST,
      "frame position beyond checksum slot")
   `XCRD_ASSERT_IMPLY(a_kind_excl, clock, reset, rsp_tvalid, !(rsp_tlast && rsp_tuser),
      "result marked both payload and verdict")
   `XCRD_ASSERT_NEXT(a_pay_step, clock, reset, advance && is_payload,
      pos_ff == $past(pos_eff) + 9'd1, "payload byte did not advance position")
   `XCRD_ASSERT_NEXT(a_verdict_rst, clock, reset, advance && is_verdict,
      pos_ff == POS_START, "verdict did not return to start position")

endmodule

`default_nettype wire
